[design/adhf_pkg.sv]
`timescale 1ns / 1ps

package adhf_pkg;

  localparam int UNIT_ONE       = 16384;
  localparam int DEADZONE_MAX   = 15565;
  localparam int STICK_AXES     = 4;
  localparam int AXIS_COUNT     = 6;
  localparam int AXIS_W         = 3;
  localparam int VALUE_W        = 16;
  localparam int MAG_W          = 15;
  localparam int DZ_W           = 15;
  localparam int THR_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int QUEUE_DEPTH    = 2;
  // 14 quotient bits after the leading one, 7 per cycle
  localparam int DIV_STEPS      = 7;
  localparam int DIV_CYCLES     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic              neg;
    logic              divide;
    logic [MAG_W-1:0]  mag;   // magnitude, or leading quotient bit when dividing
    logic [MAG_W-1:0]  rem;   // partial remainder when dividing
    logic [MAG_W-1:0]  den;   // divisor when dividing
  } entry_t;

endpackage

[design/axis_deadzone_hysteresis_filter_unit.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-----------------------------------
// in_      | input     | in_valid / in_ready  | in_axis_index, in_raw_sample
// out_     | output    | out_valid / out_ready| out_axis_echo, out_filtered_value,
//          |           |                      | out_changed
// cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item enters the queue at the edge that accepts it. For a stick item outside the
// deadzone the back end loads it from the queue, runs the divider (seven quotient
// bits a cycle), then publishes the result; other items go from load to publish.
// The back end takes no new item until it has published the one it holds.
// Reset (rst_n low, synchronous) clears the config and control registers, the queue
// and the per-axis history. The two-entry queue takes items while the back end stalls, until full.

module axis_deadzone_hysteresis_filter_unit import adhf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [AXIS_W-1:0]         in_axis_index,
  input  logic signed [VALUE_W-1:0] in_raw_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [AXIS_W-1:0]         out_axis_echo,
  output logic signed [VALUE_W-1:0] out_filtered_value,
  output logic                      out_changed,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  logic [DZ_W-1:0]  deadzone_r;
  logic [THR_W-1:0] threshold_r;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_not_empty;
  entry_t           push_entry;
  entry_t           head_entry;

  // Config writes are always taken; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r  <= '0;
      threshold_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEADZONE:  deadzone_r  <= cfg_data[DZ_W-1:0];
        CFG_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: clamp, apply deadzone, set up the division.
  adhf_front u_front (
    .in_valid      (in_valid),
    .in_axis_index (in_axis_index),
    .in_raw_sample (in_raw_sample),
    .deadzone      (deadzone_r),
    .q_full        (q_full),
    .in_ready      (in_ready),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  // Hold classified items between the two sides.
  adhf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head_entry)
  );

  // Back: divide, restore sign, compare against history, publish.
  adhf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (q_not_empty),
    .q_head             (head_entry),
    .q_pop              (q_pop),
    .threshold          (threshold_r),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_axis_echo      (out_axis_echo),
    .out_filtered_value (out_filtered_value),
    .out_changed        (out_changed)
  );

endmodule

[design/adhf_front.sv]
`timescale 1ns / 1ps

module adhf_front import adhf_pkg::*; (
  input  logic                      in_valid,
  input  logic [AXIS_W-1:0]         in_axis_index,
  input  logic signed [VALUE_W-1:0] in_raw_sample,
  input  logic [DZ_W-1:0]           deadzone,
  input  logic                      q_full,
  output logic                      in_ready,
  output logic                      q_push,
  output entry_t                    q_entry
);

  logic [VALUE_W:0] raw_ext;
  logic [VALUE_W:0] abs_raw;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] dz;
  logic [MAG_W-1:0] num;
  logic [MAG_W-1:0] den;
  logic             is_stick;
  logic             lead;

  always_comb begin
    raw_ext  = {in_raw_sample[VALUE_W-1], in_raw_sample};
    abs_raw  = in_raw_sample[VALUE_W-1] ? ((VALUE_W+1)'(0) - raw_ext) : raw_ext;
    // clamp to 1.0
    mag      = (abs_raw > (VALUE_W+1)'(UNIT_ONE)) ? MAG_W'(UNIT_ONE) : abs_raw[MAG_W-1:0];
    dz       = (deadzone > DZ_W'(DEADZONE_MAX)) ? MAG_W'(DEADZONE_MAX) : deadzone;
    num      = mag - dz;
    den      = MAG_W'(UNIT_ONE) - dz;
    lead     = (num == den);
    is_stick = (in_axis_index < AXIS_W'(STICK_AXES));

    q_entry.axis   = in_axis_index;
    q_entry.neg    = in_raw_sample[VALUE_W-1];
    q_entry.divide = 1'b0;
    q_entry.mag    = mag;
    q_entry.rem    = '0;
    q_entry.den    = den;
    if (is_stick) begin
      if (mag <= dz) begin
        // inside the deadzone: drop to zero
        q_entry.neg = 1'b0;
        q_entry.mag = '0;
      end else begin
        q_entry.divide = 1'b1;
        q_entry.mag    = MAG_W'(lead);
        q_entry.rem    = lead ? '0 : num;
      end
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

[design/adhf_queue.sv]
`timescale 1ns / 1ps

module adhf_queue import adhf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt;
  logic [PTR_W-1:0]   rd_r, rd_nxt;
  logic [PTR_W:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  assign full      = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

endmodule

[design/adhf_back.sv]
`timescale 1ns / 1ps

module adhf_back import adhf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  input  entry_t                    q_head,
  output logic                      q_pop,
  input  logic [THR_W-1:0]          threshold,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [AXIS_W-1:0]         out_axis_echo,
  output logic signed [VALUE_W-1:0] out_filtered_value,
  output logic                      out_changed
);

  localparam int CNT_W = $clog2(DIV_CYCLES);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [AXIS_W-1:0]         axis_r, axis_nxt;
  logic                      neg_r, neg_nxt;
  logic [MAG_W-1:0]          q_r, q_nxt;
  logic [MAG_W-1:0]          rem_r, rem_nxt;
  logic [MAG_W-1:0]          den_r, den_nxt;
  logic signed [VALUE_W-1:0] last_r [AXIS_COUNT];
  logic                      out_valid_r, out_valid_nxt;
  logic [AXIS_W-1:0]         out_axis_r, out_axis_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                      out_chg_r, out_chg_nxt;

  logic [MAG_W:0]            r2;
  logic                      ge;
  logic [MAG_W-1:0]          r_step;
  logic [MAG_W-1:0]          q_step;
  logic signed [VALUE_W-1:0] cur;
  logic signed [VALUE_W-1:0] prev;
  logic [VALUE_W:0]          diff;
  logic [VALUE_W:0]          abs_diff;
  logic                      has_state;
  logic                      chg;
  logic                      publish;

  // seven restoring steps per cycle
  always_comb begin
    r_step = rem_r;
    q_step = q_r;
    r2     = '0;
    ge     = 1'b0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r2     = {r_step, 1'b0};
      ge     = (r2 >= {1'b0, den_r});
      r_step = ge ? MAG_W'(r2 - {1'b0, den_r}) : r2[MAG_W-1:0];
      q_step = {q_step[MAG_W-2:0], ge};
    end
  end

  always_comb begin
    cur       = neg_r ? (VALUE_W'(0) - {1'b0, q_r}) : {1'b0, q_r};
    has_state = (axis_r < AXIS_W'(AXIS_COUNT));
    prev      = has_state ? last_r[axis_r] : '0;
    diff      = {cur[VALUE_W-1], cur} - {prev[VALUE_W-1], prev};
    abs_diff  = diff[VALUE_W] ? ((VALUE_W+1)'(0) - diff) : diff;
    chg       = has_state && (prev != cur) &&
                ((prev == '0) || (cur == '0) || (abs_diff >= {1'b0, threshold}));
    publish   = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    axis_nxt      = axis_r;
    neg_nxt       = neg_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_axis_nxt  = out_axis_r;
    out_value_nxt = out_value_r;
    out_chg_nxt   = out_chg_r;
    q_pop         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          axis_nxt  = q_head.axis;
          neg_nxt   = q_head.neg;
          q_nxt     = q_head.mag;
          rem_nxt   = q_head.rem;
          den_nxt   = q_head.den;
          cnt_nxt   = '0;
          state_nxt = q_head.divide ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        q_nxt   = q_step;
        rem_nxt = r_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_CYCLES - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (publish) begin
          out_valid_nxt = 1'b1;
          out_axis_nxt  = axis_r;
          out_value_nxt = cur;
          out_chg_nxt   = chg;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    axis_r      <= axis_nxt;
    neg_r       <= neg_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    out_axis_r  <= out_axis_nxt;
    out_value_r <= out_value_nxt;
    out_chg_r   <= out_chg_nxt;
  end

  // last published value per axis, updated only on a change
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        last_r[i] <= '0;
      end
    end else if (publish && chg) begin
      last_r[axis_r] <= cur;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_axis_echo      = out_axis_r;
  assign out_filtered_value = out_value_r;
  assign out_changed        = out_chg_r;

endmodule

[tb/sv/axis_deadzone_hysteresis_filter_unit_tb.sv]
`timescale 1ns / 1ps

module axis_deadzone_hysteresis_filter_unit_tb;
  import adhf_pkg::*;

  // Register indexes that the block decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int PHASES        = 13;
  localparam int PHASE_ITEMS   = 100;
  localparam int MAX_IDLE      = 17;
  localparam int DRAIN_CYCLES  = 20;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed script: an item or a register write. A pinned item
  // carries its expected value and change flag typed in by hand.
  typedef struct packed {
    row_kind_t              kind;
    logic [AXIS_W-1:0]      axis;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [15:0]            data;
    logic                   pinned;
    logic [VALUE_W-1:0]     pin_value;
    logic                   pin_changed;
  } script_row_t;

  typedef struct packed {
    logic [AXIS_W-1:0]  axis;
    logic [VALUE_W-1:0] value;
    logic               changed;
  } axis_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [AXIS_W-1:0]         in_axis_index = '0;
  logic signed [VALUE_W-1:0] in_raw_sample = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [AXIS_W-1:0]         out_axis_echo;
  logic signed [VALUE_W-1:0] out_filtered_value;
  logic                      out_changed;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // Shadow of the block: register settings and the last published value per axis
  logic [DZ_W-1:0]  deadzone_setting = '0;
  logic [THR_W-1:0] threshold_setting = '0;
  int               published [AXIS_COUNT];
  int               recent_raw [8];

  axis_result_t pending_results [$];
  script_row_t  script [$];
  int           mismatches = 0;
  bit           src_idle_on = 1'b1;
  bit           sink_idle_on = 1'b1;

  axis_deadzone_hysteresis_filter_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_axis_index      (in_axis_index),
    .in_raw_sample      (in_raw_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_axis_echo      (out_axis_echo),
    .out_filtered_value (out_filtered_value),
    .out_changed        (out_changed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #1 clk = ~clk;

  // Clamp to +/-1.0, then apply the scaled deadzone on stick axes only.
  function automatic int filtered_sample(input logic [AXIS_W-1:0] axis,
                                         input logic signed [VALUE_W-1:0] raw);
    int v;
    int dz;
    int mag;
    int scaled;
    v = raw;
    if (v > UNIT_ONE) v = UNIT_ONE;
    else if (v < -UNIT_ONE) v = -UNIT_ONE;
    if (axis >= STICK_AXES) return v;
    dz = (deadzone_setting > DEADZONE_MAX) ? DEADZONE_MAX : int'(deadzone_setting);
    mag = (v < 0) ? -v : v;
    if (mag <= dz) return 0;
    scaled = ((mag - dz) * UNIT_ONE) / (UNIT_ONE - dz);
    if (scaled > UNIT_ONE) scaled = UNIT_ONE;
    return (v < 0) ? -scaled : scaled;
  endfunction

  // Equal never counts; entering or leaving zero always counts.
  function automatic bit is_change(input int prev, input int cur);
    int diff;
    if (prev == cur) return 1'b0;
    if (prev == 0 || cur == 0) return 1'b1;
    diff = (cur > prev) ? cur - prev : prev - cur;
    return diff >= int'(threshold_setting);
  endfunction

  function automatic script_row_t item_row(input int axis, input int raw);
    script_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.axis = axis[AXIS_W-1:0];
    r.data = raw[15:0];
    return r;
  endfunction

  function automatic script_row_t pinned_row(input int axis, input int raw,
                                             input int value, input bit changed);
    script_row_t r;
    r = item_row(axis, raw);
    r.pinned = 1'b1;
    r.pin_value = value[VALUE_W-1:0];
    r.pin_changed = changed;
    return r;
  endfunction

  function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input int data);
    script_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.data = data[15:0];
    return r;
  endfunction

  // Pick a raw sample: full range, deadzone and clamp edges, zero, repeats,
  // and small walks so the threshold decides often.
  function automatic logic [15:0] pick_raw(input logic [AXIS_W-1:0] axis);
    int r;
    int dz;
    int step;
    dz = (deadzone_setting > DEADZONE_MAX) ? DEADZONE_MAX : int'(deadzone_setting);
    case ($urandom_range(0, 9))
      0, 1: r = int'($urandom_range(0, 65535)) - 32768;
      2: r = dz + int'($urandom_range(0, 4)) - 2;
      3: r = UNIT_ONE + int'($urandom_range(0, 4)) - 2;
      4: r = 0;
      5: r = recent_raw[axis];
      default: begin
        step = $urandom_range(0, 1) ? int'($urandom_range(0, 64))
                                    : int'($urandom_range(0, 1024));
        r = recent_raw[axis] + int'($urandom_range(0, 2 * step)) - step;
      end
    endcase
    if (($urandom_range(0, 1) == 1) && (r >= 2 && r <= UNIT_ONE + 2)) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    recent_raw[axis] = r;
    return r[15:0];
  endfunction

  // Present one item, hold it until taken, then record what it must produce.
  task automatic send_item(input logic [AXIS_W-1:0] axis,
                           input logic signed [VALUE_W-1:0] raw,
                           input bit pinned,
                           input logic [VALUE_W-1:0] pin_value,
                           input bit pin_changed);
    int gap;
    int cur;
    bit chg;
    axis_result_t want;
    gap = src_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_axis_index <= axis;
    in_raw_sample <= raw;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    cur = filtered_sample(axis, raw);
    chg = 1'b0;
    // Axes past the history table never report and never store
    if (axis < AXIS_COUNT) begin
      chg = is_change(published[axis], cur);
      if (chg) published[axis] = cur;
    end
    want.axis    = axis;
    want.value   = pinned ? pin_value : cur[VALUE_W-1:0];
    want.changed = pinned ? pin_changed : chg;
    pending_results.push_back(want);
  endtask

  // Drain the pipe, then write one register. cfg_valid stays up so that
  // back-to-back writes never lower and raise it in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    if (idx == CFG_DEADZONE) deadzone_setting = data[DZ_W-1:0];
    else if (idx == CFG_THRESHOLD) threshold_setting = data[THR_W-1:0];
  endtask

  // Result sink: stall a random count before each item, sometimes not at all.
  initial begin : result_sink
    int stall;
    forever begin
      stall = sink_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    axis_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result axis %0d value %0d changed %0d",
                 $time, out_axis_echo, out_filtered_value, out_changed);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_axis_echo !== want.axis) begin
          $display("%0t: axis_echo expected %0d got %0d",
                   $time, want.axis, out_axis_echo);
          mismatches++;
        end
        if (out_filtered_value !== want.value) begin
          $display("%0t: filtered_value expected %0d got %0d (axis %0d)",
                   $time, $signed(want.value), out_filtered_value, want.axis);
          mismatches++;
        end
        if (out_changed !== want.changed) begin
          $display("%0t: changed expected %0d got %0d (axis %0d)",
                   $time, want.changed, out_changed, want.axis);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [AXIS_W-1:0] axis;
    logic [2:0]        spare_axis;
    int                pick;
    for (int i = 0; i < AXIS_COUNT; i++) published[i] = 0;
    for (int i = 0; i < 8; i++) recent_raw[i] = 0;

    // Directed script: reset defaults first, then the deadzone extremes.
    script.push_back(pinned_row(0, 0, 0, 1'b0));           // equal at zero, threshold 0
    script.push_back(pinned_row(0, 32767, 16384, 1'b1));   // clamp high, full scale
    script.push_back(pinned_row(0, -32768, -16384, 1'b1)); // clamp low
    script.push_back(pinned_row(4, 16384, 16384, 1'b1));   // trigger pass-through
    script.push_back(pinned_row(4, 16384, 16384, 1'b0));   // same value again
    script.push_back(pinned_row(5, -1, -1, 1'b1));
    script.push_back(pinned_row(6, 20000, 16384, 1'b0));   // axis without history
    script.push_back(pinned_row(7, -20000, -16384, 1'b0));
    script.push_back(pinned_row(1, 1, 1, 1'b1));
    script.push_back(cfg_row(CFG_DEADZONE, 16384));        // acts as the 0.95 cap
    script.push_back(cfg_row(CFG_THRESHOLD, 32768));
    script.push_back(pinned_row(2, 15565, 0, 1'b0));       // exactly on the deadzone
    script.push_back(pinned_row(2, 15566, 20, 1'b1));      // leaving zero beats threshold
    script.push_back(pinned_row(2, -16384, -16384, 1'b0)); // big move, still below
    script.push_back(pinned_row(2, 0, 0, 1'b1));           // back to zero
    script.push_back(cfg_row(CFG_DEADZONE, 16'hFFFF));     // top bit dropped, capped
    script.push_back(cfg_row(CFG_SPARE_LO, 16'h1234));     // ignored
    script.push_back(cfg_row(CFG_SPARE_HI, 16'hFFFF));     // ignored
    script.push_back(item_row(3, 16000));
    script.push_back(pinned_row(3, -15000, 0, 1'b1));
    script.push_back(cfg_row(CFG_DEADZONE, 8192));
    script.push_back(cfg_row(CFG_THRESHOLD, 100));
    script.push_back(item_row(0, 8193));
    script.push_back(item_row(0, 8250));
    script.push_back(item_row(0, 8240));                   // below threshold, kept
    script.push_back(pinned_row(1, -8192, 0, 1'b1));
    script.push_back(item_row(4, -32768));
    script.push_back(cfg_row(CFG_THRESHOLD, 65535));
    script.push_back(cfg_row(CFG_DEADZONE, 0));
    script.push_back(pinned_row(4, 16384, 16384, 1'b0));   // full swing under max threshold
    script.push_back(pinned_row(5, 16383, 16383, 1'b0));
    script.push_back(pinned_row(1, 16385, 16384, 1'b1));

    // Hold reset, then release it for good.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG)
        write_reg(script[i].reg_idx, script[i].data);
      else
        send_item(script[i].axis, script[i].data, script[i].pinned,
                  script[i].pin_value, script[i].pin_changed);
    end

    // Random phases: new settings each time, then a burst of items.
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 6))
        0: write_reg(CFG_DEADZONE, CFG_DATA_W'(0));
        1: write_reg(CFG_DEADZONE, CFG_DATA_W'(1));
        2: write_reg(CFG_DEADZONE, CFG_DATA_W'(DEADZONE_MAX));
        3: write_reg(CFG_DEADZONE, CFG_DATA_W'(DEADZONE_MAX + 1));
        4: write_reg(CFG_DEADZONE, CFG_DATA_W'(UNIT_ONE));
        5: write_reg(CFG_DEADZONE, 16'hFFFF);
        default: write_reg(CFG_DEADZONE, CFG_DATA_W'($urandom_range(0, 65535)));
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(CFG_THRESHOLD, CFG_DATA_W'(0));
        1: write_reg(CFG_THRESHOLD, CFG_DATA_W'(1));
        2: write_reg(CFG_THRESHOLD, CFG_DATA_W'(32768));
        3: write_reg(CFG_THRESHOLD, 16'hFFFF);
        4: write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(1, 64)));
        5: write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(1, 2000)));
        default: write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 65535)));
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                  CFG_DATA_W'($urandom_range(0, 65535)));
      // Drop idling on one side or both for whole phases now and then
      src_idle_on  = ($urandom_range(0, 2) != 0);
      sink_idle_on = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          spare_axis = AXIS_W'($urandom_range(AXIS_COUNT, 7));
          axis = spare_axis;
        end else begin
          pick = $urandom_range(0, AXIS_COUNT - 1);
          axis = pick[AXIS_W-1:0];
        end
        send_item(axis, pick_raw(axis), 1'b0, '0, 1'b0);
      end
    end

    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Leave room for any stray result to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
